/* rtl/jsu_pkg.sv */
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int unsigned MaxResults = 5;
  localparam int unsigned CountWidth = 3;

  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharN         = 8'h6E;
  localparam logic [7:0] CharR         = 8'h72;
  localparam logic [7:0] CharT         = 8'h74;
  localparam logic [7:0] CharU         = 8'h75;
  localparam logic [7:0] CharNewline   = 8'h0A;
  localparam logic [7:0] CharReturn    = 8'h0D;
  localparam logic [7:0] CharTab       = 8'h09;

  localparam logic [15:0] Utf8Max1 = 16'h007F;
  localparam logic [15:0] Utf8Max2 = 16'h07FF;
  localparam logic [7:0]  Utf8Lead2 = 8'hC0;
  localparam logic [7:0]  Utf8Lead3 = 8'hE0;
  localparam logic [7:0]  Utf8Cont  = 8'h80;

  typedef enum logic [2:0] {
    MODE_AWAIT = 3'd0,
    MODE_STR   = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_HEX   = 3'd3,
    MODE_SKIP  = 3'd4
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
  } result_t;

  typedef struct packed {
    logic [CountWidth-1:0]         count;
    result_t [MaxResults-1:0]      res;
  } cmd_t;

endpackage

/* rtl/jsu_front.sv */
`timescale 1ns / 1ps

module jsu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            buffer_end,
  input  logic            queue_full,
  output logic            push,
  output jsu_pkg::cmd_t   push_cmd
);

  jsu_pkg::mode_t mode, mode_next;
  logic [1:0]     digit_count, digit_count_next;
  logic [15:0]    code_value, code_value_next;
  logic [7:0]     held_digits [3];
  logic           take;
  logic [4:0]     hex_val;
  logic           hex_ok;
  logic [15:0]    cp;
  jsu_pkg::cmd_t  cmd;

  always_comb begin
    hex_val = 5'h10;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = {1'b0, in_byte[3:0]};
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_val = {1'b0, in_byte[3:0] + 4'd9};
    end
  end

  assign hex_ok   = ~hex_val[4];
  assign cp       = {code_value[11:0], hex_val[3:0]};
  assign in_ready = ~queue_full;
  assign take     = in_valid & in_ready;

  // Next-state logic.
  always_comb begin
    mode_next        = mode;
    digit_count_next = digit_count;
    code_value_next  = code_value;
    case (mode)
      jsu_pkg::MODE_STR: begin
        if (in_byte == jsu_pkg::CharQuote) begin
          mode_next = buffer_end ? jsu_pkg::MODE_AWAIT : jsu_pkg::MODE_SKIP;
        end else if (in_byte == jsu_pkg::CharBackslash && !buffer_end) begin
          mode_next = jsu_pkg::MODE_ESC;
        end else begin
          mode_next = buffer_end ? jsu_pkg::MODE_AWAIT : jsu_pkg::MODE_STR;
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (in_byte == jsu_pkg::CharU && !buffer_end) begin
          mode_next        = jsu_pkg::MODE_HEX;
          digit_count_next = 2'd0;
          code_value_next  = 16'h0000;
        end else begin
          mode_next = buffer_end ? jsu_pkg::MODE_AWAIT : jsu_pkg::MODE_STR;
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (!hex_ok) begin
          digit_count_next = 2'd0;
          if (in_byte == jsu_pkg::CharQuote) begin
            mode_next = buffer_end ? jsu_pkg::MODE_AWAIT : jsu_pkg::MODE_SKIP;
          end else if (in_byte == jsu_pkg::CharBackslash && !buffer_end) begin
            mode_next = jsu_pkg::MODE_ESC;
          end else begin
            mode_next = buffer_end ? jsu_pkg::MODE_AWAIT : jsu_pkg::MODE_STR;
          end
        end else if (digit_count == 2'd3) begin
          code_value_next  = cp;
          digit_count_next = 2'd0;
          mode_next        = buffer_end ? jsu_pkg::MODE_AWAIT : jsu_pkg::MODE_STR;
        end else begin
          code_value_next  = cp;
          digit_count_next = buffer_end ? 2'd0 : digit_count + 2'd1;
          if (buffer_end) begin
            mode_next = jsu_pkg::MODE_AWAIT;
          end
        end
      end
      jsu_pkg::MODE_SKIP: begin
        if (buffer_end) begin
          mode_next = jsu_pkg::MODE_AWAIT;
        end
      end
      default: begin
        if (in_byte == jsu_pkg::CharQuote) begin
          mode_next = buffer_end ? jsu_pkg::MODE_AWAIT : jsu_pkg::MODE_STR;
        end else begin
          mode_next = buffer_end ? jsu_pkg::MODE_AWAIT : jsu_pkg::MODE_SKIP;
        end
      end
    endcase
  end

  // Result list for the current byte.
  always_comb begin
    logic [2:0] n;
    logic [7:0] esc_byte;
    logic       esc_known;
    n         = 3'd0;
    esc_byte  = in_byte;
    esc_known = 1'b0;
    cmd       = '0;
    case (mode)
      jsu_pkg::MODE_STR: begin
        if (in_byte == jsu_pkg::CharQuote) begin
          cmd.res[n] = '{8'h00, 1'b0, 1'b1}; n = n + 3'd1;
        end else if (!(in_byte == jsu_pkg::CharBackslash && !buffer_end)) begin
          cmd.res[n] = '{in_byte, 1'b1, 1'b0}; n = n + 3'd1;
          if (buffer_end) begin
            cmd.res[n] = '{8'h00, 1'b0, 1'b1}; n = n + 3'd1;
          end
        end
      end
      jsu_pkg::MODE_ESC: begin
        case (in_byte)
          jsu_pkg::CharN: begin esc_byte = jsu_pkg::CharNewline; esc_known = 1'b1; end
          jsu_pkg::CharR: begin esc_byte = jsu_pkg::CharReturn; esc_known = 1'b1; end
          jsu_pkg::CharT: begin esc_byte = jsu_pkg::CharTab; esc_known = 1'b1; end
          jsu_pkg::CharQuote, jsu_pkg::CharBackslash: begin
            esc_known = 1'b1;
          end
          default: esc_known = 1'b0;
        endcase
        if (esc_known) begin
          cmd.res[n] = '{esc_byte, 1'b1, 1'b0}; n = n + 3'd1;
        end
        if (buffer_end) begin
          cmd.res[n] = '{8'h00, 1'b0, 1'b1}; n = n + 3'd1;
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (!hex_ok) begin
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < digit_count) begin
              cmd.res[n] = '{held_digits[i], 1'b1, 1'b0}; n = n + 3'd1;
            end
          end
          if (in_byte == jsu_pkg::CharQuote) begin
            cmd.res[n] = '{8'h00, 1'b0, 1'b1}; n = n + 3'd1;
          end else if (!(in_byte == jsu_pkg::CharBackslash && !buffer_end)) begin
            cmd.res[n] = '{in_byte, 1'b1, 1'b0}; n = n + 3'd1;
            if (buffer_end) begin
              cmd.res[n] = '{8'h00, 1'b0, 1'b1}; n = n + 3'd1;
            end
          end
        end else if (digit_count == 2'd3) begin
          if (cp <= jsu_pkg::Utf8Max1) begin
            cmd.res[n] = '{cp[7:0], 1'b1, 1'b0}; n = n + 3'd1;
          end else if (cp <= jsu_pkg::Utf8Max2) begin
            cmd.res[n] = '{jsu_pkg::Utf8Lead2 | {3'b000, cp[10:6]}, 1'b1, 1'b0};
            n = n + 3'd1;
            cmd.res[n] = '{jsu_pkg::Utf8Cont | {2'b00, cp[5:0]}, 1'b1, 1'b0};
            n = n + 3'd1;
          end else begin
            cmd.res[n] = '{jsu_pkg::Utf8Lead3 | {4'h0, cp[15:12]}, 1'b1, 1'b0};
            n = n + 3'd1;
            cmd.res[n] = '{jsu_pkg::Utf8Cont | {2'b00, cp[11:6]}, 1'b1, 1'b0};
            n = n + 3'd1;
            cmd.res[n] = '{jsu_pkg::Utf8Cont | {2'b00, cp[5:0]}, 1'b1, 1'b0};
            n = n + 3'd1;
          end
          if (buffer_end) begin
            cmd.res[n] = '{8'h00, 1'b0, 1'b1}; n = n + 3'd1;
          end
        end else if (buffer_end) begin
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < digit_count) begin
              cmd.res[n] = '{held_digits[i], 1'b1, 1'b0}; n = n + 3'd1;
            end
          end
          cmd.res[n] = '{in_byte, 1'b1, 1'b0}; n = n + 3'd1;
          cmd.res[n] = '{8'h00, 1'b0, 1'b1}; n = n + 3'd1;
        end
      end
      jsu_pkg::MODE_SKIP: begin
        n = 3'd0;
      end
      default: begin
        if (in_byte != jsu_pkg::CharQuote || buffer_end) begin
          cmd.res[n] = '{8'h00, 1'b0, 1'b1}; n = n + 3'd1;
        end
      end
    endcase
    cmd.count = n;
  end

  assign push     = take && (cmd.count != '0);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= jsu_pkg::MODE_AWAIT;
      digit_count <= 2'd0;
      code_value  <= 16'h0000;
    end else if (take) begin
      mode        <= mode_next;
      digit_count <= digit_count_next;
      code_value  <= code_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && mode == jsu_pkg::MODE_HEX && hex_ok && digit_count != 2'd3) begin
      held_digits[digit_count] <= in_byte;
    end
  end

endmodule

/* rtl/jsu_queue.sv */
`timescale 1ns / 1ps

module jsu_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output jsu_pkg::cmd_t head_cmd,
  output logic          empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;

  assign full     = (fill == CW'(DEPTH));
  assign empty    = (fill == '0);
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* rtl/jsu_back.sv */
`timescale 1ns / 1ps

module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          queue_empty,
  input  jsu_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic          string_done
);

  jsu_pkg::cmd_t                      cur;
  logic                               busy;
  logic [jsu_pkg::CountWidth-1:0]     idx;
  logic                               out_free;
  logic                               send;
  logic                               last_one;
  jsu_pkg::result_t                   r;

  assign out_free = ~out_valid | out_ready;
  assign send     = busy & out_free;
  assign last_one = (idx == cur.count - jsu_pkg::CountWidth'(1));
  assign pop      = ~queue_empty & (~busy | (send & last_one));
  assign r        = cur.res[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (send) begin
        idx <= idx + jsu_pkg::CountWidth'(1);
        if (last_one) begin
          busy <= 1'b0;
        end
      end
      if (send) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_cmd;
    end
    if (send) begin
      out_byte    <= r.out_byte;
      byte_valid  <= r.byte_valid;
      string_done <= r.string_done;
    end
  end

endmodule

/* rtl/json_string_unescape_utf8.sv */
`timescale 1ns / 1ps

// Decodes one quoted JSON string per input buffer, one raw byte per transfer, into UTF-8
// bytes followed by an end marker (tlast high, tuser low). The front end takes one byte
// every cycle as long as its command queue has room; each byte turns into zero to five
// results, and the output port delivers one result per cycle while m_tready is high, so
// the sustained rate is one byte per cycle while bytes average at most one result each.
// A byte with k results holds the output until all k are sent, and QUEUE_DEPTH commands
// absorb such bursts. A result passes the queue, the cur register and out_byte in turn.
module json_string_unescape_utf8 #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic       s_tlast,   // buffer_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tuser,   // byte_valid
  output logic       m_tlast    // string_done
);

  logic          push, pop, full, empty;
  jsu_pkg::cmd_t push_cmd, head_cmd;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .buffer_end (s_tlast),
    .queue_full (full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (empty)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (empty),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte    (m_tdata),
    .byte_valid  (m_tuser),
    .string_done (m_tlast)
  );

endmodule

/* verif/tb_json_string_unescape_utf8.sv */
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;

  localparam int CycleLimit = 200000;
  localparam int PhaseBytes = 40;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 20;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } raw_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;

  raw_byte_t          pending_bytes[$];
  jsu_pkg::result_t   decoded_q[$];

  // Decoder state kept alongside the block.
  jsu_pkg::mode_t st_mode = jsu_pkg::MODE_AWAIT;
  logic [1:0]     st_count = 2'd0;
  logic [7:0]     st_held[3] = '{8'h00, 8'h00, 8'h00};
  logic [15:0]    st_code = 16'h0000;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  in_taken = 1'b0;
  bit  hold_arm = 1'b0;
  int  hold_left = 0;
  int  cycle_count = 0;
  int  fail_count = 0;

  json_string_unescape_utf8 dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
    if (n < 4'd10) return 8'h30 + {4'd0, n};
    return (upper ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    jsu_pkg::result_t r;
    r.out_byte = b;
    r.byte_valid = 1'b1;
    r.string_done = 1'b0;
    decoded_q.insert(decoded_q.size(), r);
  endtask

  task automatic put_end();
    jsu_pkg::result_t r;
    r.out_byte = 8'h00;
    r.byte_valid = 1'b0;
    r.string_done = 1'b1;
    decoded_q.insert(decoded_q.size(), r);
  endtask

  task automatic put_utf8(input logic [15:0] cp);
    if (cp <= jsu_pkg::Utf8Max1) begin
      put_byte(cp[7:0]);
    end else if (cp <= jsu_pkg::Utf8Max2) begin
      put_byte(jsu_pkg::Utf8Lead2 | {3'd0, cp[10:6]});
      put_byte(jsu_pkg::Utf8Cont | {2'd0, cp[5:0]});
    end else begin
      put_byte(jsu_pkg::Utf8Lead3 | {4'd0, cp[15:12]});
      put_byte(jsu_pkg::Utf8Cont | {2'd0, cp[11:6]});
      put_byte(jsu_pkg::Utf8Cont | {2'd0, cp[5:0]});
    end
  endtask

  task automatic flush_held();
    for (int i = 0; i < int'(st_count); i++) put_byte(st_held[i]);
    st_count = 2'd0;
  endtask

  task automatic string_char(input logic [7:0] b, input logic last);
    if (b == jsu_pkg::CharQuote) begin
      put_end();
      st_mode = last ? jsu_pkg::MODE_AWAIT : jsu_pkg::MODE_SKIP;
    end else if (b == jsu_pkg::CharBackslash && !last) begin
      st_mode = jsu_pkg::MODE_ESC;
    end else begin
      put_byte(b);
      st_mode = jsu_pkg::MODE_STR;
      if (last) begin
        put_end();
        st_mode = jsu_pkg::MODE_AWAIT;
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    int h;
    case (st_mode)
      jsu_pkg::MODE_STR: string_char(b, last);
      jsu_pkg::MODE_ESC: begin
        st_mode = jsu_pkg::MODE_STR;
        case (b)
          jsu_pkg::CharN:         put_byte(jsu_pkg::CharNewline);
          jsu_pkg::CharR:         put_byte(jsu_pkg::CharReturn);
          jsu_pkg::CharT:         put_byte(jsu_pkg::CharTab);
          jsu_pkg::CharQuote:     put_byte(jsu_pkg::CharQuote);
          jsu_pkg::CharBackslash: put_byte(jsu_pkg::CharBackslash);
          jsu_pkg::CharU: begin
            if (!last) begin
              st_mode = jsu_pkg::MODE_HEX;
              st_count = 2'd0;
              st_code = 16'h0000;
            end
          end
          default: ;
        endcase
        if (last) begin
          put_end();
          st_mode = jsu_pkg::MODE_AWAIT;
        end
      end
      jsu_pkg::MODE_HEX: begin
        h = hex_value(b);
        if (h < 0) begin
          flush_held();
          string_char(b, last);
        end else if (st_count == 2'd3) begin
          st_code = {st_code[11:0], h[3:0]};
          st_count = 2'd0;
          put_utf8(st_code);
          st_mode = jsu_pkg::MODE_STR;
          if (last) begin
            put_end();
            st_mode = jsu_pkg::MODE_AWAIT;
          end
        end else begin
          st_held[st_count] = b;
          st_count = st_count + 2'd1;
          st_code = {st_code[11:0], h[3:0]};
          if (last) begin
            flush_held();
            put_end();
            st_mode = jsu_pkg::MODE_AWAIT;
          end
        end
      end
      jsu_pkg::MODE_SKIP: begin
        if (last) st_mode = jsu_pkg::MODE_AWAIT;
      end
      default: begin
        if (b == jsu_pkg::CharQuote) begin
          st_mode = jsu_pkg::MODE_STR;
          if (last) begin
            put_end();
            st_mode = jsu_pkg::MODE_AWAIT;
          end
        end else begin
          put_end();
          st_mode = last ? jsu_pkg::MODE_AWAIT : jsu_pkg::MODE_SKIP;
        end
      end
    endcase
  endtask

  task automatic queue_buffer(input logic [7:0] bq[$]);
    raw_byte_t item;
    for (int i = 0; i < bq.size(); i++) begin
      item.data = bq[i];
      item.last = (i == bq.size() - 1);
      pending_bytes.insert(pending_bytes.size(), item);
    end
  endtask

  // Builds one buffer, mostly a well-formed string with random content, and
  // returns how many of its bytes are not trailing junk after the close.
  task automatic add_random_buffer(output int counted);
    logic [7:0]  bq[$];
    logic [7:0]  b;
    logic [15:0] cp;
    int          junk;
    int          cut;
    int          ndig;
    junk = 0;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) bq.insert(bq.size(), 8'($urandom_range(255)));
    end else begin
      bq.insert(bq.size(), jsu_pkg::CharQuote);
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(9))
          0, 1, 2: begin
            do begin
              b = 8'($urandom_range(255));
            end while (b == jsu_pkg::CharQuote || b == jsu_pkg::CharBackslash);
            bq.insert(bq.size(), b);
          end
          3, 4: begin
            bq.insert(bq.size(), jsu_pkg::CharBackslash);
            case ($urandom_range(9))
              0: bq.insert(bq.size(), jsu_pkg::CharN);
              1: bq.insert(bq.size(), jsu_pkg::CharR);
              2: bq.insert(bq.size(), jsu_pkg::CharT);
              3: bq.insert(bq.size(), jsu_pkg::CharQuote);
              4: bq.insert(bq.size(), jsu_pkg::CharBackslash);
              default: bq.insert(bq.size(), 8'($urandom_range(255)));
            endcase
          end
          5, 6, 7: begin
            case ($urandom_range(3))
              0: cp = 16'($urandom_range('h7F));
              1: cp = 16'($urandom_range('h7FF, 'h80));
              2: cp = 16'($urandom_range('hFFFF, 'h800));
              default: cp = 16'($urandom_range('hDFFF, 'hD800));
            endcase
            bq.insert(bq.size(), jsu_pkg::CharBackslash);
            bq.insert(bq.size(), jsu_pkg::CharU);
            bq.insert(bq.size(), hex_char(cp[15:12], 1'($urandom_range(1))));
            bq.insert(bq.size(), hex_char(cp[11:8], 1'($urandom_range(1))));
            bq.insert(bq.size(), hex_char(cp[7:4], 1'($urandom_range(1))));
            bq.insert(bq.size(), hex_char(cp[3:0], 1'($urandom_range(1))));
          end
          8: begin
            bq.insert(bq.size(), jsu_pkg::CharBackslash);
            bq.insert(bq.size(), jsu_pkg::CharU);
            ndig = $urandom_range(0, 3);
            repeat (ndig) begin
              bq.insert(bq.size(),
                        hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            end
            do b = 8'($urandom_range(255)); while (hex_value(b) >= 0);
            bq.insert(bq.size(), b);
          end
          default: bq.insert(bq.size(), 8'($urandom_range('h7E, 'h20)));
        endcase
      end
      if ($urandom_range(3) == 0) begin
        cut = $urandom_range(1, bq.size());
        while (bq.size() > cut) void'(bq.pop_back());
      end else begin
        bq.insert(bq.size(), jsu_pkg::CharQuote);
        junk = $urandom_range(0, 2);
        repeat (junk) bq.insert(bq.size(), 8'($urandom_range(255)));
      end
    end
    counted = bq.size() - junk;
    queue_buffer(bq);
  endtask

  // Sender: holds each byte until its transfer, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata <= pending_bytes[0].data;
        s_tlast <= pending_bytes[0].last;
        s_tvalid <= 1'b1;
        void'(pending_bytes.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst || hold_left > 0) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (hold_arm) begin
      hold_left = HoldCycles;
      hold_arm = 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    jsu_pkg::result_t want;
    in_taken = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        decode_byte(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (decoded_q.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("Unexpected result: byte %02h valid %0d done %0d",
                     m_tdata, m_tuser, m_tlast);
        end else begin
          want = decoded_q.pop_front();
          if (m_tdata !== want.out_byte || m_tuser !== want.byte_valid ||
              m_tlast !== want.string_done) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("Mismatch: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                       want.out_byte, want.byte_valid, want.string_done,
                       m_tdata, m_tuser, m_tlast);
          end
        end
      end
    end
  end

  initial begin
    logic [7:0] dq[$];
    int n;
    int got;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Every simple escape, unknown escape, extreme bytes, trailing backslash.
    dq = '{jsu_pkg::CharQuote, 8'h00, 8'hFF, jsu_pkg::CharBackslash, jsu_pkg::CharN,
           jsu_pkg::CharBackslash, jsu_pkg::CharR, jsu_pkg::CharBackslash,
           jsu_pkg::CharT, jsu_pkg::CharBackslash, jsu_pkg::CharQuote,
           jsu_pkg::CharBackslash, jsu_pkg::CharBackslash, jsu_pkg::CharBackslash,
           8'h71, jsu_pkg::CharBackslash};
    queue_buffer(dq);
    // No opening quote, then an opening quote as the final byte.
    dq = '{8'h78, 8'h71};
    queue_buffer(dq);
    dq = '{jsu_pkg::CharQuote};
    queue_buffer(dq);
    // Empty string closed on the final byte.
    dq = '{jsu_pkg::CharQuote, jsu_pkg::CharQuote};
    queue_buffer(dq);
    // A full unicode escape, then a bad hex digit after one held digit.
    dq = '{jsu_pkg::CharQuote, jsu_pkg::CharBackslash, jsu_pkg::CharU, 8'h30, 8'h30,
           8'h65, 8'h39, jsu_pkg::CharBackslash, jsu_pkg::CharU, 8'h31, 8'h47};
    queue_buffer(dq);

    for (int ph = 0; ph < 4; ph++) begin
      while (pending_bytes.size() != 0 || s_tvalid) @(negedge clk);
      case (ph)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 50; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 50; end
        default: begin send_idle_pct = 29; recv_idle_pct = 29; end
      endcase
      n = 0;
      while (n < PhaseBytes) begin
        add_random_buffer(got);
        n = n + got;
      end
      // The receiver stops for a long stretch while the sender keeps offering.
      if (ph == 0) hold_arm = 1'b1;
    end

    while (pending_bytes.size() != 0 || s_tvalid) @(negedge clk);
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (decoded_q.size() != 0) fail_count = fail_count + 1;
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
